// ----- hw/rtl/msh_pkg.sv -----
// Package for the multi-set histogram binner: sizes, codes, state and command types.
`timescale 1ns / 1ps
`default_nettype none

package msh_pkg;

  // Store geometry and counter width.
  localparam int MAX_BINS    = 1024;
  localparam int NUM_SETS    = 4;
  localparam int COUNT_WIDTH = 32;

  // Fixed field widths of the ports.
  localparam int OP_W       = 1;
  localparam int SAMPLE_W   = 24;
  localparam int SET_NUM_W  = 3;
  localparam int READ_BIN_W = 10;
  localparam int STATUS_W   = 2;
  localparam int LANDED_W   = 10;
  localparam int OUT_CNT_W  = 32;
  localparam int PCT_W      = 7;
  localparam int WIDTH_W    = 24;
  localparam int BINS_CFG_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // Derived sizes.
  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int NB_W   = $clog2(MAX_BINS + 1);
  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int DEPTH  = NUM_SETS * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);

  // Percent is count * 100 / total, with only eight quotient bits developed.
  localparam int PCT_SCALE = 100;
  localparam int PCT_QBITS = 8;
  localparam int DEN_W     = (COUNT_WIDTH > WIDTH_W) ? COUNT_WIDTH : WIDTH_W;
  localparam int NUM_W     = ((COUNT_WIDTH + 7) > SAMPLE_W) ? (COUNT_WIDTH + 7) : SAMPLE_W;
  localparam int STEP_W    = $clog2(SAMPLE_W + 1);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0]  CFG_BIN_WIDTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_BINS_IN_USE = 1'd1;
  localparam logic [WIDTH_W-1:0]    BIN_WIDTH_RST   = 24'd256;
  localparam logic [BINS_CFG_W-1:0] BINS_IN_USE_RST = 11'd1024;

  // Operation and status codes.
  localparam logic [OP_W-1:0]     OP_ADD       = 1'b0;
  localparam logic [OP_W-1:0]     OP_READ      = 1'b1;
  localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_SET = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_BIN = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_DIV_S,
    S_ROUND,
    S_MEM_RD,
    S_MEM_USE,
    S_PCT_MUL,
    S_PCT_CHK,
    S_PCT_DIV,
    S_FINISH
  } msh_state_t;

  typedef struct packed {
    logic clr_en;
    logic in_load;
    logic err_set;
    logic err_bin;
    logic bin_last;
    logic bin_read;
    logic div_start;
    logic div_pct;
    logic round;
    logic mem_use;
    logic pct_mul;
    logic pct_zero;
    logic pct_full;
    logic pct_take;
    logic out_load;
  } msh_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_read;
    logic set_bad;
    logic bin_bad;
    logic width_zero;
    logic div_done;
    logic tot_zero;
    logic pct_big;
    logic out_free;
  } msh_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/msh_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module msh_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [msh_pkg::STEP_W-1:0]  steps,
  input  wire logic [msh_pkg::DEN_W-1:0]   rem_init,
  input  wire logic [msh_pkg::NUM_W-1:0]   num_init,
  input  wire logic [msh_pkg::DEN_W-1:0]   den,
  output logic                             done,
  output logic [msh_pkg::NUM_W-1:0]        num,
  output logic [msh_pkg::DEN_W-1:0]        rem
);

  logic                         busy_r;
  logic                         done_r;
  logic [msh_pkg::STEP_W-1:0]   cnt_r;
  logic [msh_pkg::DEN_W-1:0]    rem_r;
  logic [msh_pkg::DEN_W-1:0]    rem_nxt;
  logic [msh_pkg::DEN_W-1:0]    den_r;
  logic [msh_pkg::NUM_W-1:0]    num_r;
  logic [msh_pkg::NUM_W-1:0]    num_nxt;
  logic [msh_pkg::DEN_W:0]      trial;
  logic [msh_pkg::DEN_W:0]      diff;
  logic                         qbit;

  // The dividend enters MSB first; quotient bits shift in at the bottom.
  always_comb begin
    trial = {rem_r, num_r[msh_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
    if (qbit) begin
      rem_nxt = diff[msh_pkg::DEN_W-1:0];
    end else begin
      rem_nxt = trial[msh_pkg::DEN_W-1:0];
    end
    num_nxt = {num_r[msh_pkg::NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - msh_pkg::STEP_W'(1);
        if (cnt_r == msh_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      num_r <= num_init;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign done = done_r;
  assign num  = num_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ----- hw/rtl/msh_dp.sv -----
// Datapath: configuration, bin store, set totals, peak, divider and result register.
`timescale 1ns / 1ps
`default_nettype none

module msh_dp (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [msh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [msh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [msh_pkg::OP_W-1:0]         in_op,
  input  wire logic [msh_pkg::SAMPLE_W-1:0]     in_sample,
  input  wire logic [msh_pkg::SET_NUM_W-1:0]    in_set_number,
  input  wire logic [msh_pkg::READ_BIN_W-1:0]   in_read_bin,
  input  wire msh_pkg::msh_cmd_t                cmd,
  output msh_pkg::msh_sts_t                     sts,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic [msh_pkg::STATUS_W-1:0]          out_status,
  output logic [msh_pkg::LANDED_W-1:0]          out_landed_bin,
  output logic [msh_pkg::OUT_CNT_W-1:0]         out_bin_count,
  output logic [msh_pkg::OUT_CNT_W-1:0]         out_set_total,
  output logic [msh_pkg::PCT_W-1:0]             out_percent,
  output logic [msh_pkg::OUT_CNT_W-1:0]         out_peak_count
);

  // Configuration.
  logic [msh_pkg::WIDTH_W-1:0]     bin_width_r;
  logic [msh_pkg::BINS_CFG_W-1:0]  bins_cfg_r;
  logic [msh_pkg::NB_W-1:0]        nb;
  logic [msh_pkg::NB_W-1:0]        last;

  // Captured transaction.
  logic [msh_pkg::OP_W-1:0]        op_r;
  logic [msh_pkg::SAMPLE_W-1:0]    sample_r;
  logic [msh_pkg::SET_NUM_W-1:0]   set_num_r;
  logic [msh_pkg::READ_BIN_W-1:0]  read_bin_r;
  logic [msh_pkg::SET_W-1:0]       set_idx;

  // Working result.
  logic [msh_pkg::STATUS_W-1:0]    status_r;
  logic [msh_pkg::BIN_W-1:0]       bin_r;
  logic [msh_pkg::COUNT_WIDTH-1:0] cnt_r;
  logic [msh_pkg::COUNT_WIDTH-1:0] tot_r;
  logic [msh_pkg::PCT_W-1:0]       pct_r;
  logic [msh_pkg::NUM_W-1:0]       n_r;

  // Persistent state.
  logic [msh_pkg::COUNT_WIDTH-1:0] tot_a [msh_pkg::NUM_SETS];
  logic [msh_pkg::COUNT_WIDTH-1:0] peak_r;
  logic [msh_pkg::COUNT_WIDTH-1:0] mem [msh_pkg::DEPTH];
  logic [msh_pkg::COUNT_WIDTH-1:0] rd_data_r;
  logic [msh_pkg::ADDR_W-1:0]      clr_addr_r;
  logic [msh_pkg::ADDR_W-1:0]      addr;
  logic [msh_pkg::COUNT_WIDTH-1:0] cnt_inc;
  logic [msh_pkg::COUNT_WIDTH-1:0] tot_cur;
  logic [msh_pkg::COUNT_WIDTH-1:0] tot_inc;
  logic                            is_add;

  // Divider hookup.
  logic [msh_pkg::STEP_W-1:0]      div_steps;
  logic [msh_pkg::DEN_W-1:0]       div_rem_init;
  logic [msh_pkg::NUM_W-1:0]       div_num_init;
  logic [msh_pkg::DEN_W-1:0]       div_den;
  logic                            div_done;
  logic [msh_pkg::NUM_W-1:0]       div_num;
  logic [msh_pkg::DEN_W-1:0]       div_rem;

  // Rounding of the sample quotient.
  logic [msh_pkg::SAMPLE_W-1:0]    q;
  logic [msh_pkg::DEN_W:0]         two_r;
  logic [msh_pkg::DEN_W:0]         w_ext;
  logic                            round_up;
  logic [msh_pkg::SAMPLE_W:0]      q_up;
  logic [msh_pkg::BIN_W-1:0]       bin_round;
  logic [msh_pkg::PCT_QBITS-1:0]   pct_q;

  // Result register.
  logic                            out_valid_r;
  logic [msh_pkg::STATUS_W-1:0]    out_status_r;
  logic [msh_pkg::LANDED_W-1:0]    out_landed_r;
  logic [msh_pkg::OUT_CNT_W-1:0]   out_cnt_r;
  logic [msh_pkg::OUT_CNT_W-1:0]   out_tot_r;
  logic [msh_pkg::PCT_W-1:0]       out_pct_r;
  logic [msh_pkg::OUT_CNT_W-1:0]   out_peak_r;

  // A bins-in-use value of zero acts as one, and one above the store as the store size.
  always_comb begin
    if (bins_cfg_r == '0) begin
      nb = msh_pkg::NB_W'(1);
    end else if (32'(bins_cfg_r) > msh_pkg::MAX_BINS) begin
      nb = msh_pkg::NB_W'(msh_pkg::MAX_BINS);
    end else begin
      nb = msh_pkg::NB_W'(bins_cfg_r);
    end
    last = nb - msh_pkg::NB_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r <= msh_pkg::BIN_WIDTH_RST;
      bins_cfg_r  <= msh_pkg::BINS_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        msh_pkg::CFG_BIN_WIDTH: begin
          bin_width_r <= cfg_wdata[msh_pkg::WIDTH_W-1:0];
        end
        msh_pkg::CFG_BINS_IN_USE: begin
          bins_cfg_r <= cfg_wdata[msh_pkg::BINS_CFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign set_idx = msh_pkg::SET_W'(set_num_r);
  assign is_add  = (op_r == msh_pkg::OP_ADD);
  assign addr    = msh_pkg::ADDR_W'(32'(set_idx) * msh_pkg::MAX_BINS + 32'(bin_r));
  assign tot_cur = tot_a[set_idx];
  assign cnt_inc = (rd_data_r == msh_pkg::CNT_MAX) ? rd_data_r
                                                   : rd_data_r + msh_pkg::COUNT_WIDTH'(1);
  assign tot_inc = (tot_cur == msh_pkg::CNT_MAX) ? tot_cur
                                                 : tot_cur + msh_pkg::COUNT_WIDTH'(1);

  // Divider operands: the sample over the bin width, or the scaled count over the total.
  // For the percent the upper bits of the dividend are preloaded as the partial
  // remainder, which is valid because the quotient is known to fit in eight bits.
  always_comb begin
    if (cmd.div_pct) begin
      div_steps    = msh_pkg::STEP_W'(msh_pkg::PCT_QBITS);
      div_rem_init = msh_pkg::DEN_W'(n_r >> msh_pkg::PCT_QBITS);
      div_num_init = msh_pkg::NUM_W'(n_r[msh_pkg::PCT_QBITS-1:0])
                     << (msh_pkg::NUM_W - msh_pkg::PCT_QBITS);
      div_den      = msh_pkg::DEN_W'(tot_r);
    end else begin
      div_steps    = msh_pkg::STEP_W'(msh_pkg::SAMPLE_W);
      div_rem_init = '0;
      div_num_init = msh_pkg::NUM_W'(sample_r) << (msh_pkg::NUM_W - msh_pkg::SAMPLE_W);
      div_den      = msh_pkg::DEN_W'(bin_width_r);
    end
  end

  msh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .steps    (div_steps),
    .rem_init (div_rem_init),
    .num_init (div_num_init),
    .den      (div_den),
    .done     (div_done),
    .num      (div_num),
    .rem      (div_rem)
  );

  // Round to nearest with ties to even, then clamp to the last bin in use.
  always_comb begin
    q         = div_num[msh_pkg::SAMPLE_W-1:0];
    two_r     = {div_rem, 1'b0};
    w_ext     = (msh_pkg::DEN_W + 1)'(bin_width_r);
    round_up  = (two_r > w_ext) || ((two_r == w_ext) && q[0]);
    q_up      = {1'b0, q} + (msh_pkg::SAMPLE_W + 1)'(round_up);
    if (32'(q_up) > 32'(last)) begin
      bin_round = msh_pkg::BIN_W'(last);
    end else begin
      bin_round = msh_pkg::BIN_W'(q_up);
    end
    pct_q     = div_num[msh_pkg::PCT_QBITS-1:0];
  end

  // Bin store: one write port shared by the clearing pass and the update.
  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.mem_use && is_add) begin
      mem[addr] <= cnt_inc;
    end
    rd_data_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_en) begin
      clr_addr_r <= clr_addr_r + msh_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < msh_pkg::NUM_SETS; i++) begin
        tot_a[i] <= '0;
      end
      peak_r <= '0;
    end else if (cmd.mem_use && is_add) begin
      tot_a[set_idx] <= tot_inc;
      if (cnt_inc > peak_r) begin
        peak_r <= cnt_inc;
      end
    end
  end

  // Working registers of the transaction in flight.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_r       <= in_op;
      sample_r   <= in_sample;
      set_num_r  <= in_set_number;
      read_bin_r <= in_read_bin;
      status_r   <= msh_pkg::STAT_DONE;
    end
    if (cmd.err_set || cmd.err_bin) begin
      status_r <= cmd.err_set ? msh_pkg::STAT_BAD_SET : msh_pkg::STAT_BAD_BIN;
      bin_r    <= '0;
      cnt_r    <= '0;
      tot_r    <= '0;
      pct_r    <= '0;
    end
    if (cmd.bin_last) begin
      bin_r <= msh_pkg::BIN_W'(last);
    end
    if (cmd.bin_read) begin
      bin_r <= msh_pkg::BIN_W'(read_bin_r);
    end
    if (cmd.round) begin
      bin_r <= bin_round;
    end
    if (cmd.mem_use) begin
      if (is_add) begin
        cnt_r <= cnt_inc;
        tot_r <= tot_inc;
      end else begin
        cnt_r <= rd_data_r;
        tot_r <= tot_cur;
      end
    end
    if (cmd.pct_mul) begin
      n_r <= msh_pkg::NUM_W'(cnt_r) * msh_pkg::NUM_W'(msh_pkg::PCT_SCALE);
    end
    if (cmd.pct_zero) begin
      pct_r <= '0;
    end
    if (cmd.pct_full) begin
      pct_r <= msh_pkg::PCT_W'(msh_pkg::PCT_SCALE);
    end
    if (cmd.pct_take) begin
      if (pct_q > msh_pkg::PCT_QBITS'(msh_pkg::PCT_SCALE)) begin
        pct_r <= msh_pkg::PCT_W'(msh_pkg::PCT_SCALE);
      end else begin
        pct_r <= msh_pkg::PCT_W'(pct_q);
      end
    end
  end

  // Result register: a finished transaction waits here while the next one is worked on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_landed_r <= msh_pkg::LANDED_W'(bin_r);
      out_cnt_r    <= msh_pkg::OUT_CNT_W'(cnt_r);
      out_tot_r    <= msh_pkg::OUT_CNT_W'(tot_r);
      out_pct_r    <= pct_r;
      out_peak_r   <= msh_pkg::OUT_CNT_W'(peak_r);
    end
  end

  always_comb begin
    sts.clr_last   = (clr_addr_r == msh_pkg::ADDR_W'(msh_pkg::DEPTH - 1));
    sts.op_read    = (op_r == msh_pkg::OP_READ);
    sts.set_bad    = (32'(set_num_r) >= msh_pkg::NUM_SETS);
    sts.bin_bad    = (32'(read_bin_r) >= 32'(nb));
    sts.width_zero = (bin_width_r == '0);
    sts.div_done   = div_done;
    sts.tot_zero   = (tot_r == '0);
    sts.pct_big    = ((n_r >> msh_pkg::PCT_QBITS) >= msh_pkg::NUM_W'(tot_r));
    sts.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_landed_bin = out_landed_r;
  assign out_bin_count  = out_cnt_r;
  assign out_set_total  = out_tot_r;
  assign out_percent    = out_pct_r;
  assign out_peak_count = out_peak_r;

endmodule

`default_nettype wire

// ----- hw/rtl/msh_ctrl.sv -----
// Controller: sequences the clearing pass and each add or read transaction.
`timescale 1ns / 1ps
`default_nettype none

module msh_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire msh_pkg::msh_sts_t sts,
  output msh_pkg::msh_cmd_t      cmd
);

  msh_pkg::msh_state_t state_r;
  msh_pkg::msh_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msh_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msh_pkg::S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = msh_pkg::S_IDLE;
        end
      end
      msh_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = msh_pkg::S_DECODE;
        end
      end
      msh_pkg::S_DECODE: begin
        if (sts.set_bad) begin
          state_nxt = msh_pkg::S_FINISH;
        end else if (sts.op_read) begin
          state_nxt = sts.bin_bad ? msh_pkg::S_FINISH : msh_pkg::S_MEM_RD;
        end else if (sts.width_zero) begin
          state_nxt = msh_pkg::S_MEM_RD;
        end else begin
          state_nxt = msh_pkg::S_DIV_S;
        end
      end
      msh_pkg::S_DIV_S: begin
        if (sts.div_done) begin
          state_nxt = msh_pkg::S_ROUND;
        end
      end
      msh_pkg::S_ROUND: begin
        state_nxt = msh_pkg::S_MEM_RD;
      end
      msh_pkg::S_MEM_RD: begin
        state_nxt = msh_pkg::S_MEM_USE;
      end
      msh_pkg::S_MEM_USE: begin
        state_nxt = msh_pkg::S_PCT_MUL;
      end
      msh_pkg::S_PCT_MUL: begin
        state_nxt = msh_pkg::S_PCT_CHK;
      end
      msh_pkg::S_PCT_CHK: begin
        if (sts.tot_zero || sts.pct_big) begin
          state_nxt = msh_pkg::S_FINISH;
        end else begin
          state_nxt = msh_pkg::S_PCT_DIV;
        end
      end
      msh_pkg::S_PCT_DIV: begin
        if (sts.div_done) begin
          state_nxt = msh_pkg::S_FINISH;
        end
      end
      msh_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = msh_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = msh_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      msh_pkg::S_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      msh_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.in_load = in_valid;
      end
      msh_pkg::S_DECODE: begin
        if (sts.set_bad) begin
          cmd.err_set = 1'b1;
        end else if (sts.op_read) begin
          cmd.err_bin  = sts.bin_bad;
          cmd.bin_read = !sts.bin_bad;
        end else if (sts.width_zero) begin
          cmd.bin_last = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      msh_pkg::S_DIV_S: begin
      end
      msh_pkg::S_ROUND: begin
        cmd.round = 1'b1;
      end
      msh_pkg::S_MEM_RD: begin
      end
      msh_pkg::S_MEM_USE: begin
        cmd.mem_use = 1'b1;
      end
      msh_pkg::S_PCT_MUL: begin
        cmd.pct_mul = 1'b1;
      end
      msh_pkg::S_PCT_CHK: begin
        if (sts.tot_zero) begin
          cmd.pct_zero = 1'b1;
        end else if (sts.pct_big) begin
          cmd.pct_full = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_pct   = 1'b1;
        end
      end
      msh_pkg::S_PCT_DIV: begin
        cmd.div_pct  = 1'b1;
        cmd.pct_take = sts.div_done;
      end
      msh_pkg::S_FINISH: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/multi_set_histogram_binner.sv -----
// Top level of the multi-set histogram binner.
`timescale 1ns / 1ps
`default_nettype none

// Keeps one histogram per set in a bin store of NUM_SETS * MAX_BINS saturating
// counts with one write port, with a saturating total per set and a peak over
// all bins. After reset the block sweeps all 4096 entries of the store to zero,
// one entry a cycle; no input transaction is taken during that pass, though
// configuration writes are. Transactions are then handled one at a time. An add
// runs the handshake and decoding, the bit-serial division of the sample by the
// bin width, one quotient bit a cycle, the rounding, the read-modify-write of the
// bin, the percent scaling, the eight-bit percent division on the same shared
// divider and the hand-over to the result register. With a zero bin width the
// sample division and the rounding are skipped. A read skips the sample division,
// and also the percent division when the set total is zero; a transaction with a
// bad set or bin goes from decoding straight to the hand-over. A finished result
// is held in an output register, so a new transaction is taken while the
// previous result still waits to be collected; the block stalls only when a
// second result is ready before the first has been taken.

module multi_set_histogram_binner (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [msh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [msh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [msh_pkg::OP_W-1:0]         in_op,
  input  wire logic [msh_pkg::SAMPLE_W-1:0]     in_sample,
  input  wire logic [msh_pkg::SET_NUM_W-1:0]    in_set_number,
  input  wire logic [msh_pkg::READ_BIN_W-1:0]   in_read_bin,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [msh_pkg::STATUS_W-1:0]          out_status,
  output logic [msh_pkg::LANDED_W-1:0]          out_landed_bin,
  output logic [msh_pkg::OUT_CNT_W-1:0]         out_bin_count,
  output logic [msh_pkg::OUT_CNT_W-1:0]         out_set_total,
  output logic [msh_pkg::PCT_W-1:0]             out_percent,
  output logic [msh_pkg::OUT_CNT_W-1:0]         out_peak_count
);

  msh_pkg::msh_cmd_t cmd;
  msh_pkg::msh_sts_t sts;

  msh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msh_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_op),
    .in_sample      (in_sample),
    .in_set_number  (in_set_number),
    .in_read_bin    (in_read_bin),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_landed_bin (out_landed_bin),
    .out_bin_count  (out_bin_count),
    .out_set_total  (out_set_total),
    .out_percent    (out_percent),
    .out_peak_count (out_peak_count)
  );

endmodule

`default_nettype wire
